/* src/nrrh_pkg.sv */
`timescale 1ns / 1ps
package nrrh_pkg;

	localparam logic [1:0] OP_WRITE  = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam int COORD_W = 24;
	localparam int SIZE_W  = 23;
	localparam int EDGE_W  = 25;
	localparam int DIFF_W  = 26;
	localparam int MUL_W   = 25;
	localparam int PROD_W  = 50;
	localparam int PT_W    = 51;
	localparam int DIST_W  = 49;
	localparam int BOX_W   = 2 * COORD_W + 2 * SIZE_W;

	localparam logic signed [PT_W-1:0] S24_MAX = PT_W'(64'sd8388607);
	localparam logic signed [PT_W-1:0] S24_MIN = PT_W'(-64'sd8388608);

	typedef struct packed {
		logic [1:0]                op;
		logic [5:0]                index;
		logic signed [COORD_W-1:0] rect_left;
		logic signed [COORD_W-1:0] rect_top;
		logic [SIZE_W-1:0]         rect_width;
		logic [SIZE_W-1:0]         rect_height;
		logic signed [COORD_W-1:0] origin_x;
		logic signed [COORD_W-1:0] origin_y;
		logic signed [COORD_W-1:0] dir_x;
		logic signed [COORD_W-1:0] dir_y;
		logic [SIZE_W-1:0]         max_dist;
	} in_t;

	typedef struct packed {
		logic                      hit;
		logic [5:0]                hit_index;
		logic signed [COORD_W-1:0] end_x;
		logic signed [COORD_W-1:0] end_y;
	} out_t;

	function automatic logic signed [COORD_W-1:0] sat24(input logic signed [PT_W-1:0] v);
		logic signed [COORD_W-1:0] r;
		if (v > S24_MAX) begin
			r = COORD_W'(S24_MAX);
		end else if (v < S24_MIN) begin
			r = COORD_W'(S24_MIN);
		end else begin
			r = v[COORD_W-1:0];
		end
		return r;
	endfunction

endpackage

/* src/nrrh_in_if.sv */
`timescale 1ns / 1ps
interface nrrh_in_if;
	logic          valid;
	logic          ready;
	nrrh_pkg::in_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* src/nrrh_out_if.sv */
`timescale 1ns / 1ps
interface nrrh_out_if;
	logic           valid;
	logic           ready;
	nrrh_pkg::out_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* src/nrrh_ram.sv */
`timescale 1ns / 1ps
module nrrh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW = 4
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

/* src/nrrh_div.sv */
`timescale 1ns / 1ps
// Restoring divider on magnitudes, one quotient bit per cycle. The quotient is
// truncated toward zero and saturated to the signed 24-bit range.
module nrrh_div #(
	parameter int NUM_W = 34
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [NUM_W-1:0]  num,
	input  logic signed [nrrh_pkg::COORD_W-1:0] den,
	output logic                     done,
	output logic signed [nrrh_pkg::COORD_W-1:0] quo
);
	localparam int CW = nrrh_pkg::COORD_W;
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic             neg_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CW-1:0]    rem_q;
	logic [CW-1:0]    dmag_q;
	logic [NUM_W-1:0] acc_q;

	logic [CW:0]      rem_sh;
	logic             qbit;
	logic [CW:0]      rem_sub;

	always_comb begin
		rem_sh = {rem_q, acc_q[NUM_W-1]};
		rem_sub = rem_sh - {1'b0, dmag_q};
		qbit = (rem_sh >= {1'b0, dmag_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			neg_q <= 1'b0;
			cnt_q <= '0;
			rem_q <= '0;
			dmag_q <= '0;
			acc_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				neg_q <= num[NUM_W-1] ^ den[CW-1];
				acc_q <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
				dmag_q <= den[CW-1] ? CW'(-den) : CW'(den);
				rem_q <= '0;
				cnt_q <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				rem_q <= qbit ? rem_sub[CW-1:0] : rem_sh[CW-1:0];
				acc_q <= {acc_q[NUM_W-2:0], qbit};
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_comb begin
		if (!neg_q) begin
			if (acc_q > NUM_W'(23'h7FFFFF)) begin
				quo = CW'(nrrh_pkg::S24_MAX);
			end else begin
				quo = acc_q[CW-1:0];
			end
		end else begin
			if (acc_q > NUM_W'(24'h800000)) begin
				quo = CW'(nrrh_pkg::S24_MIN);
			end else begin
				quo = -acc_q[CW-1:0];
			end
		end
	end

	assign done = done_q;
endmodule

/* src/nearest_ray_rectangle_hit_unit.sv */
`timescale 1ns / 1ps
// Channel  Dir  Modport  Contents
// req      in   sink     op, index, rectangle, ray origin, direction, max_dist
// rsp      out  source   hit, hit_index, end_x, end_y (one per ray query)
//
// Write, remove and the unused op finish in S_IDLE. A query finds the ray end in
// S_EXA, S_EXB and S_EXC; an empty entry then passes S_RD and S_ADV, a stored
// one S_RD, S_LOAD, S_CONT and S_ADV, and S_FIN hands off the result. Each slab
// axis tried adds two serial divisions on the shared divider and S_MULX, S_MULY
// and S_CHK for the hit point; a hit adds S_SQX, S_SQY, S_CMP for the distance.
// Reset clears the valid bits; the rectangle memory is not cleared.
// A finished result waits in the output register; the next query finishes only
// after it has been taken.
module nearest_ray_rectangle_hit_unit #(
	parameter int ENTRIES = 64,
	parameter int FRAC_BITS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	nrrh_in_if.sink    req,
	nrrh_out_if.source rsp
);
	localparam int CW = nrrh_pkg::COORD_W;
	localparam int SW = nrrh_pkg::SIZE_W;
	localparam int EW = nrrh_pkg::EDGE_W;
	localparam int DW = nrrh_pkg::DIFF_W;
	localparam int MW = nrrh_pkg::MUL_W;
	localparam int PW = nrrh_pkg::PROD_W;
	localparam int TW = nrrh_pkg::PT_W;
	localparam int QW = nrrh_pkg::DIST_W;
	localparam int BW = nrrh_pkg::BOX_W;
	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int NUM_W = DW + FRAC_BITS;
	localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

	typedef enum logic [4:0] {
		S_IDLE, S_EXA, S_EXB, S_EXC, S_RD, S_LOAD, S_CONT, S_DIVA, S_WAITA,
		S_DIVB, S_WAITB, S_MULX, S_MULY, S_CHK, S_SQX, S_SQY, S_CMP, S_ADV, S_FIN
	} state_t;

	state_t state_q;

	logic [ENTRIES-1:0]   valid_q;
	logic [AW-1:0]        i_q;
	logic                 axis_y_q;
	logic signed [CW-1:0] ox_q, oy_q, dx_q, dy_q, t_q, t1_q;
	logic [SW-1:0]        maxd_q;
	logic signed [CW-1:0] bl_q, bt_q;
	logic signed [EW-1:0] br_q, bb_q;
	logic signed [PW-1:0] prod_q;
	logic signed [TW-1:0] px_q;
	logic signed [CW-1:0] sx_q, sy_q;
	logic [QW-1:0]        dist_q, bestd_q;
	logic                 found_q;
	logic [AW-1:0]        best_q;
	logic signed [CW-1:0] ex_q, ey_q;
	logic                 out_valid_q;
	nrrh_pkg::out_t       out_q;

	logic                 in_fire;
	logic                 in_range;
	logic                 ram_we;
	logic                 ram_re;
	logic [BW-1:0]        ram_rdata;

	logic signed [MW-1:0] mul_a, mul_b;
	logic signed [TW-1:0] prod_sh;
	logic signed [TW-1:0] pt_sum;
	logic signed [CW-1:0] o_sel, d_sel;
	logic signed [EW-1:0] edge_sel;
	logic signed [DW-1:0] diff;
	logic signed [NUM_W-1:0] div_num;
	logic                 div_start, div_done;
	logic signed [CW-1:0] div_quo;
	logic signed [CW-1:0] t_min;
	logic                 t_ok;
	logic                 contained;
	logic                 slab_pass;
	logic [QW-1:0]        dist_sum;
	logic                 out_free;

	assign in_fire = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign in_range = (32'(req.data.index) < 32'(ENTRIES));
	assign ram_we = in_fire && (req.data.op == nrrh_pkg::OP_WRITE) && in_range;
	assign ram_re = (state_q == S_RD) && valid_q[i_q];
	assign out_free = !out_valid_q || rsp.ready;

	nrrh_ram #(.WIDTH(BW), .DEPTH(ENTRIES), .AW(AW)) u_box_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(req.data.index)),
		.wdata ({req.data.rect_left, req.data.rect_top, req.data.rect_width,
			req.data.rect_height}),
		.re    (ram_re),
		.raddr (i_q),
		.rdata (ram_rdata)
	);

	// Shared multiplier: ray scaling by t, then the squared distance terms.
	always_comb begin
		case (state_q)
			S_EXA, S_MULX: begin
				mul_a = MW'(dx_q);
				mul_b = MW'(t_q);
			end
			S_EXB, S_MULY: begin
				mul_a = MW'(dy_q);
				mul_b = MW'(t_q);
			end
			S_SQX: begin
				mul_a = MW'(sx_q) - MW'(ox_q);
				mul_b = MW'(sx_q) - MW'(ox_q);
			end
			S_SQY: begin
				mul_a = MW'(sy_q) - MW'(oy_q);
				mul_b = MW'(sy_q) - MW'(oy_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Arithmetic shift gives the floor of the scaled product.
	always_comb begin
		prod_sh = TW'(prod_q) >>> FRAC_BITS;
		case (state_q)
			S_EXC, S_CHK: pt_sum = TW'(oy_q) + prod_sh;
			default: pt_sum = TW'(ox_q) + prod_sh;
		endcase
	end

	always_comb begin
		o_sel = axis_y_q ? oy_q : ox_q;
		d_sel = axis_y_q ? dy_q : dx_q;
		if (state_q == S_DIVB) begin
			edge_sel = axis_y_q ? bb_q : br_q;
		end else begin
			edge_sel = axis_y_q ? EW'(bt_q) : EW'(bl_q);
		end
		diff = DW'(edge_sel) - DW'(o_sel);
		div_num = NUM_W'(diff) <<< FRAC_BITS;
		div_start = (state_q == S_DIVA) || (state_q == S_DIVB);
	end

	nrrh_div #(.NUM_W(NUM_W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (d_sel),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_comb begin
		t_min = (t1_q < div_quo) ? t1_q : div_quo;
		t_ok = (t_min >= 0) && (t_min <= $signed({1'b0, maxd_q}));
		contained = (EW'(ox_q) >= EW'(bl_q)) && (EW'(ox_q) < br_q)
			&& (EW'(oy_q) >= EW'(bt_q)) && (EW'(oy_q) < bb_q);
		if (axis_y_q) begin
			slab_pass = (px_q >= TW'(bl_q)) && (px_q <= TW'(br_q));
		end else begin
			slab_pass = (pt_sum >= TW'(bt_q)) && (pt_sum <= TW'(bb_q));
		end
		dist_sum = dist_q + prod_q[QW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			i_q <= '0;
			axis_y_q <= 1'b0;
			ox_q <= '0;
			oy_q <= '0;
			dx_q <= '0;
			dy_q <= '0;
			t_q <= '0;
			t1_q <= '0;
			maxd_q <= '0;
			bl_q <= '0;
			bt_q <= '0;
			br_q <= '0;
			bb_q <= '0;
			prod_q <= '0;
			px_q <= '0;
			sx_q <= '0;
			sy_q <= '0;
			dist_q <= '0;
			bestd_q <= '0;
			found_q <= 1'b0;
			best_q <= '0;
			ex_q <= '0;
			ey_q <= '0;
			out_valid_q <= 1'b0;
			out_q <= '0;
		end else begin
			// In S_FIN the handoff below decides the output valid on its own.
			if (out_valid_q && rsp.ready && (state_q != S_FIN)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						if (req.data.op == nrrh_pkg::OP_WRITE && in_range) begin
							valid_q[AW'(req.data.index)] <= 1'b1;
						end else if (req.data.op == nrrh_pkg::OP_REMOVE && in_range) begin
							valid_q[AW'(req.data.index)] <= 1'b0;
						end else if (req.data.op == nrrh_pkg::OP_QUERY) begin
							ox_q <= req.data.origin_x;
							oy_q <= req.data.origin_y;
							dx_q <= req.data.dir_x;
							dy_q <= req.data.dir_y;
							maxd_q <= req.data.max_dist;
							t_q <= CW'(req.data.max_dist);
							i_q <= '0;
							found_q <= 1'b0;
							best_q <= '0;
							state_q <= S_EXA;
						end
					end
				end
				S_EXA: begin
					prod_q <= mul_a * mul_b;
					state_q <= S_EXB;
				end
				S_EXB: begin
					ex_q <= nrrh_pkg::sat24(pt_sum);
					prod_q <= mul_a * mul_b;
					state_q <= S_EXC;
				end
				S_EXC: begin
					ey_q <= nrrh_pkg::sat24(pt_sum);
					state_q <= S_RD;
				end
				S_RD: begin
					state_q <= valid_q[i_q] ? S_LOAD : S_ADV;
				end
				S_LOAD: begin
					bl_q <= ram_rdata[BW-1 -: CW];
					bt_q <= ram_rdata[BW-CW-1 -: CW];
					br_q <= EW'(signed'(ram_rdata[BW-1 -: CW]))
						+ EW'(ram_rdata[2*SW-1 -: SW]);
					bb_q <= EW'(signed'(ram_rdata[BW-CW-1 -: CW]))
						+ EW'(ram_rdata[SW-1:0]);
					state_q <= S_CONT;
				end
				S_CONT: begin
					if (contained) begin
						state_q <= S_ADV;
					end else if (dx_q != 0) begin
						axis_y_q <= 1'b0;
						state_q <= S_DIVA;
					end else if (dy_q != 0) begin
						axis_y_q <= 1'b1;
						state_q <= S_DIVA;
					end else begin
						state_q <= S_ADV;
					end
				end
				S_DIVA: state_q <= S_WAITA;
				S_WAITA: begin
					if (div_done) begin
						t1_q <= div_quo;
						state_q <= S_DIVB;
					end
				end
				S_DIVB: state_q <= S_WAITB;
				S_WAITB: begin
					if (div_done) begin
						if (t_ok) begin
							t_q <= t_min;
							state_q <= S_MULX;
						end else if (!axis_y_q && dy_q != 0) begin
							axis_y_q <= 1'b1;
							state_q <= S_DIVA;
						end else begin
							state_q <= S_ADV;
						end
					end
				end
				S_MULX: begin
					prod_q <= mul_a * mul_b;
					state_q <= S_MULY;
				end
				S_MULY: begin
					px_q <= pt_sum;
					prod_q <= mul_a * mul_b;
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (slab_pass) begin
						sx_q <= nrrh_pkg::sat24(px_q);
						sy_q <= nrrh_pkg::sat24(pt_sum);
						state_q <= S_SQX;
					end else if (!axis_y_q && dy_q != 0) begin
						axis_y_q <= 1'b1;
						state_q <= S_DIVA;
					end else begin
						state_q <= S_ADV;
					end
				end
				S_SQX: begin
					prod_q <= mul_a * mul_b;
					state_q <= S_SQY;
				end
				S_SQY: begin
					dist_q <= prod_q[QW-1:0];
					prod_q <= mul_a * mul_b;
					state_q <= S_CMP;
				end
				S_CMP: begin
					// Strict compare keeps the earliest entry on equal distance.
					if (!found_q || dist_sum < bestd_q) begin
						found_q <= 1'b1;
						bestd_q <= dist_sum;
						best_q <= i_q;
						ex_q <= sx_q;
						ey_q <= sy_q;
					end
					state_q <= S_ADV;
				end
				S_ADV: begin
					if (i_q == LAST) begin
						state_q <= S_FIN;
					end else begin
						i_q <= i_q + AW'(1);
						state_q <= S_RD;
					end
				end
				S_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_q.hit <= found_q;
						out_q.hit_index <= 6'(best_q);
						out_q.end_x <= ex_q;
						out_q.end_y <= ey_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data = out_q;
endmodule

/* sim/nrrh_checker.sv */
`timescale 1ns / 1ps
module nrrh_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic           req_ready,
	input  nrrh_pkg::in_t  req_data,
	input  logic           rsp_valid,
	input  logic           rsp_ready,
	input  nrrh_pkg::out_t rsp_data,
	output int             fail_count,
	output int             pending_hits
);
	localparam int N_BOXES = 64;

	logic signed [23:0] tbl_left [N_BOXES];
	logic signed [23:0] tbl_top [N_BOXES];
	logic [22:0]        tbl_w [N_BOXES];
	logic [22:0]        tbl_h [N_BOXES];
	logic               tbl_valid [N_BOXES];
	nrrh_pkg::out_t     expected_hits [$];

	assign pending_hits = expected_hits.size();

	function automatic longint clamp24(input longint v);
		if (v > 8388607) return 8388607;
		if (v < -8388608) return -8388608;
		return v;
	endfunction

	// The arithmetic shift of a signed longint is a floor division by 2^8.
	function automatic longint scale_down(input longint v);
		return v >>> 8;
	endfunction

	function automatic longint edge_param(input longint edge_pos, input longint o,
			input longint d);
		longint num;
		num = (edge_pos - o) * 256;
		return clamp24(num / d);
	endfunction

	function automatic bit box_hit(input int i, input longint ox, input longint oy,
			input longint dx, input longint dy, input longint maxd,
			output longint hx, output longint hy);
		longint l, tp, r, b, t, px, py, t1, t2;
		l = tbl_left[i];
		tp = tbl_top[i];
		r = l + longint'(tbl_w[i]);
		b = tp + longint'(tbl_h[i]);
		hx = 0;
		hy = 0;
		if (ox >= l && ox < r && oy >= tp && oy < b) return 0;
		if (dx != 0) begin
			t1 = edge_param(l, ox, dx);
			t2 = edge_param(r, ox, dx);
			t = (t1 < t2) ? t1 : t2;
			if (t >= 0 && t <= maxd) begin
				px = ox + scale_down(dx * t);
				py = oy + scale_down(dy * t);
				if (py >= tp && py <= b) begin
					hx = px;
					hy = py;
					return 1;
				end
			end
		end
		if (dy != 0) begin
			t1 = edge_param(tp, oy, dy);
			t2 = edge_param(b, oy, dy);
			t = (t1 < t2) ? t1 : t2;
			if (t >= 0 && t <= maxd) begin
				px = ox + scale_down(dx * t);
				py = oy + scale_down(dy * t);
				if (px >= l && px <= r) begin
					hx = px;
					hy = py;
					return 1;
				end
			end
		end
		return 0;
	endfunction

	function automatic nrrh_pkg::out_t nearest_hit(input nrrh_pkg::in_t q);
		nrrh_pkg::out_t res;
		longint ox, oy, dx, dy, maxd, hx, hy, sx, sy, ex, ey, best_d, sq_dist;
		bit found;
		ox = q.origin_x;
		oy = q.origin_y;
		dx = q.dir_x;
		dy = q.dir_y;
		maxd = longint'(q.max_dist);
		ex = clamp24(ox + scale_down(dx * maxd));
		ey = clamp24(oy + scale_down(dy * maxd));
		found = 0;
		best_d = 0;
		res.hit_index = '0;
		for (int i = 0; i < N_BOXES; i++) begin
			if (tbl_valid[i] && box_hit(i, ox, oy, dx, dy, maxd, hx, hy)) begin
				sx = clamp24(hx);
				sy = clamp24(hy);
				sq_dist = (sx - ox) * (sx - ox) + (sy - oy) * (sy - oy);
				if (!found || sq_dist < best_d) begin
					found = 1;
					best_d = sq_dist;
					res.hit_index = 6'(i);
					ex = sx;
					ey = sy;
				end
			end
		end
		res.hit = found;
		res.end_x = 24'(ex);
		res.end_y = 24'(ey);
		return res;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		foreach (tbl_valid[i]) tbl_valid[i] = 0;
	end

	always @(posedge clk) begin
		nrrh_pkg::out_t want;
		if (arst_n && req_valid && req_ready) begin
			case (req_data.op)
				nrrh_pkg::OP_WRITE: begin
					tbl_left[req_data.index] = req_data.rect_left;
					tbl_top[req_data.index] = req_data.rect_top;
					tbl_w[req_data.index] = req_data.rect_width;
					tbl_h[req_data.index] = req_data.rect_height;
					tbl_valid[req_data.index] = 1;
				end
				nrrh_pkg::OP_REMOVE: tbl_valid[req_data.index] = 0;
				nrrh_pkg::OP_QUERY: expected_hits.push_back(nearest_hit(req_data));
				default: ;
			endcase
		end
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_hits.size() == 0) begin
				report_mismatch("unexpected transaction", 1, 0);
			end else begin
				want = expected_hits.pop_front();
				if (rsp_data.hit !== want.hit)
					report_mismatch("hit", rsp_data.hit, want.hit);
				if (rsp_data.hit_index !== want.hit_index)
					report_mismatch("hit_index", rsp_data.hit_index, want.hit_index);
				if (rsp_data.end_x !== want.end_x)
					report_mismatch("end_x", rsp_data.end_x, want.end_x);
				if (rsp_data.end_y !== want.end_y)
					report_mismatch("end_y", rsp_data.end_y, want.end_y);
			end
		end
	end
endmodule

/* sim/tb_nearest_ray_rectangle_hit_unit.sv */
`timescale 1ns / 1ps
module tb_nearest_ray_rectangle_hit_unit;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending_hits;
	int   send_idle_pct;
	int   recv_idle_pct;
	bit   hold_off;
	longint cycle_count;

	nrrh_in_if  req ();
	nrrh_out_if rsp ();

	nearest_ray_rectangle_hit_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	nrrh_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req.valid),
		.req_ready(req.ready),
		.req_data(req.data),
		.rsp_valid(rsp.valid),
		.rsp_ready(rsp.ready),
		.rsp_data(rsp.data),
		.fail_count(fail_count),
		.pending_hits(pending_hits)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Queries are slow, so the limit is generous.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 64'd20000000) begin
			$display("tb_nearest_ray_rectangle_hit_unit failed");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (hold_off || !arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	function automatic logic signed [23:0] pick_coord();
		case ($urandom_range(5))
			0: return 24'sh7FFFFF;
			1: return 24'sh800000;
			2: return 24'($urandom);
			default: return 24'(int'($urandom_range(8000)) - 4000);
		endcase
	endfunction

	function automatic logic [22:0] pick_size();
		case ($urandom_range(4))
			0: return 23'h7FFFFF;
			1: return 23'h0;
			2: return 23'($urandom);
			default: return 23'($urandom_range(2000));
		endcase
	endfunction

	// Valid stays high after acceptance until the next item or an idle cycle
	// replaces it at the following falling edge.
	task automatic send(input nrrh_pkg::in_t item);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.data <= item;
		req.valid <= 1'b1;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_write(input int idx, input logic signed [23:0] l,
			input logic signed [23:0] t, input logic [22:0] w, input logic [22:0] h);
		nrrh_pkg::in_t item;
		item = nrrh_pkg::in_t'($urandom);
		item.op = nrrh_pkg::OP_WRITE;
		item.index = 6'(idx);
		item.rect_left = l;
		item.rect_top = t;
		item.rect_width = w;
		item.rect_height = h;
		send(item);
	endtask

	task automatic send_query(input logic signed [23:0] ox, input logic signed [23:0] oy,
			input logic signed [23:0] dx, input logic signed [23:0] dy,
			input logic [22:0] md);
		nrrh_pkg::in_t item;
		item = nrrh_pkg::in_t'({$urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom});
		item.op = nrrh_pkg::OP_QUERY;
		item.origin_x = ox;
		item.origin_y = oy;
		item.dir_x = dx;
		item.dir_y = dy;
		item.max_dist = md;
		send(item);
	endtask

	task automatic send_other(input logic [1:0] op, input int idx);
		nrrh_pkg::in_t item;
		item = nrrh_pkg::in_t'({$urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom});
		item.op = op;
		item.index = 6'(idx);
		send(item);
	endtask

	task automatic random_item();
		int idx;
		int kind;
		idx = $urandom_range(63);
		kind = $urandom_range(99);
		if (kind < 30) begin
			send_write(idx, pick_coord(), pick_coord(), pick_size(), pick_size());
		end else if (kind < 38) begin
			send_other(nrrh_pkg::OP_REMOVE, idx);
		end else if (kind < 41) begin
			send_other(nrrh_pkg::OP_UNUSED, idx);
		end else begin
			send_query(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
				($urandom_range(3) == 0) ? 23'($urandom) : 23'($urandom_range(4096)));
		end
	endtask

	task automatic long_hold();
		fork
			begin
				hold_off = 1;
				repeat (3000) @(posedge clk);
				hold_off = 0;
			end
			repeat (4) send_query(24'sd0, 24'sd0, 24'sd256, 24'sd100, 23'd4096);
		join
	endtask

	initial begin
		cycle_count = 0;
		send_idle_pct = 11;
		recv_idle_pct = 55;
		hold_off = 0;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.data = '0;
		rsp.ready = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty table, zero direction, extremes, unused op, removal.
		send_query(24'sd0, 24'sd0, 24'sd256, 24'sd0, 23'd100);
		send_write(0, 24'sd256, -24'sd256, 23'd512, 23'd512);
		send_write(1, 24'sd1024, -24'sd256, 23'd512, 23'd512);
		send_write(63, 24'sh800000, 24'sh800000, 23'h7FFFFF, 23'h7FFFFF);
		send_query(24'sd0, 24'sd0, 24'sd256, 24'sd0, 23'd2560);
		send_query(24'sd0, 24'sd0, 24'sd0, 24'sd0, 23'h7FFFFF);
		send_query(24'sd300, 24'sd0, 24'sd256, 24'sd0, 23'd2560);
		send_query(24'sd512, -24'sd1024, 24'sd0, 24'sd256, 23'd2560);
		send_query(24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000, 24'sh800000, 23'h7FFFFF);
		send_query(24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 23'h7FFFFF);
		send_query(-24'sd100, 24'sd0, 24'sd1, -24'sd1, 23'h7FFFFF);
		send_write(2, 24'sd0, 24'sd0, 23'd0, 23'd0);
		send_query(-24'sd256, 24'sd0, 24'sd256, 24'sd0, 23'd512);
		send_other(nrrh_pkg::OP_UNUSED, 5);
		send_other(nrrh_pkg::OP_REMOVE, 0);
		send_other(nrrh_pkg::OP_REMOVE, 63);
		send_query(24'sd0, 24'sd0, 24'sd256, 24'sd0, 23'd2560);
		send_query(24'sd0, 24'sd0, -24'sd256, 24'sd0, 23'd0);

		long_hold();

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 55 : 0;
			recv_idle_pct = (phase == 0) ? 55 : (phase == 1) ? 11 : 0;
			repeat (160) random_item();
		end
		req.valid <= 1'b0;

		while (pending_hits != 0) @(posedge clk);
		repeat (2000) @(posedge clk);
		if (fail_count == 0) begin
			$display("tb_nearest_ray_rectangle_hit_unit passed");
		end else begin
			$display("tb_nearest_ray_rectangle_hit_unit failed");
		end
		$finish;
	end
endmodule
